// ===== rtl/iace_pkg.sv =====
// Shared types, fit coefficients and fixed-point helpers for the iced
// coefficient increments unit. No dependencies.
package iace_pkg;

    typedef logic signed [63:0] t_q32;
    typedef logic [0:4][63:0] t_coef5;

    localparam int unsigned MUL_LAT    = 3;
    localparam int unsigned PIPE_DEPTH = 7 * MUL_LAT;

    localparam t_q32 Q32_ONE = 64'sd4294967296;
    localparam t_q32 DEG_PER_RAD =
        (64'sd180 * 64'sd4294967296 * 64'sd10000000) / 64'sd31415927;

    localparam t_q32 LIFT_SPLIT  = 64'sd16 * 64'sd4294967296;
    localparam t_q32 HINGE_SPLIT = 64'sd13 * 64'sd4294967296;

    localparam t_coef5 LIFT_LO_C = '{
        (64'sd40859 * Q32_ONE) / 64'sd1000000000,
        (-64'sd5459 * Q32_ONE) / 64'sd10000000,
        (64'sd4836 * Q32_ONE) / 64'sd1000000,
        (64'sd88449 * Q32_ONE) / 64'sd1000000,
        64'd0};
    localparam t_coef5 LIFT_HI_C = '{
        (64'sd1142 * Q32_ONE) / 64'sd1000000,
        (-64'sd76707 * Q32_ONE) / 64'sd1000000,
        (64'sd16861 * Q32_ONE) / 64'sd10000,
        (-64'sd11838 * Q32_ONE) / 64'sd1000,
        64'd0};
    localparam t_coef5 DRAG_C = '{
        (64'sd23384 * Q32_ONE) / 64'sd10000000000,
        (-64'sd47511 * Q32_ONE) / 64'sd1000000000,
        (-64'sd46253 * Q32_ONE) / 64'sd100000000,
        (64'sd1578 * Q32_ONE) / 64'sd1000000,
        (-64'sd89 * Q32_ONE) / 64'sd10000};
    localparam t_coef5 PITCH_A_C = '{
        (64'sd17594 * Q32_ONE) / 64'sd10000000000,
        (-64'sd40692 * Q32_ONE) / 64'sd1000000000,
        (64'sd10205 * Q32_ONE) / 64'sd1000000000,
        (-64'sd56476 * Q32_ONE) / 64'sd10000000,
        (-64'sd1892 * Q32_ONE) / 64'sd100000};
    localparam t_coef5 PITCH_E_C = '{
        (-64'sd18439 * Q32_ONE) / 64'sd10000000000,
        (-64'sd11304 * Q32_ONE) / 64'sd1000000000,
        (64'sd39086 * Q32_ONE) / 64'sd100000000,
        64'd0,
        64'd0};
    localparam t_coef5 HINGE_A_C = '{
        (64'sd54536 * Q32_ONE) / 64'sd100000000000,
        (64'sd15911 * Q32_ONE) / 64'sd1000000000,
        (-64'sd22705 * Q32_ONE) / 64'sd100000000,
        (-64'sd12862 * Q32_ONE) / 64'sd10000000,
        64'd0};

    localparam t_q32 PM_E0 = (-64'sd14928 * Q32_ONE) / 64'sd1000000;
    localparam t_q32 PM_EA = (-64'sd37783 * Q32_ONE) / 64'sd10000000;
    localparam t_q32 HM_E0 = (-64'sd11851 * Q32_ONE) / 64'sd10000000;
    localparam t_q32 HM_ED = (-64'sd49924 * Q32_ONE) / 64'sd100000000;

    function automatic t_q32 sat_add(input t_q32 a, input t_q32 b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    // Floor shift by 12, then clamp to 32 bits.
    function automatic logic [31:0] to_out(input t_q32 v);
        t_q32 q;
        q = v >>> 12;
        if (q > 64'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end
        if (q < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return q[31:0];
    endfunction

    // Severity map entry k: 0.3 - 0.3297 * exp(-10/depth)^k, evaluated at elaboration.
    function automatic t_q32 sev_entry(input int unsigned depth, input int unsigned k);
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] negs;
        logic [63:0] step;
        logic [63:0] e;
        logic [63:0] c03;
        logic [63:0] c3297;
        z     = (64'd10 << 32) / 64'(depth);
        term  = 64'd1 << 32;
        pos   = term;
        negs  = 64'd0;
        c03   = (64'd3 << 32) / 64'd10;
        c3297 = (64'd3297 << 32) / 64'd10000;
        for (int unsigned j = 1; j <= 24; j++) begin
            term = ((term * z) >> 32) / 64'(j);
            if (j % 2 == 1) begin
                negs = negs + term;
            end else begin
                pos = pos + term;
            end
        end
        step = pos - negs;
        e    = 64'd1 << 32;
        for (int unsigned j = 0; j < k; j++) begin
            e = (e * step) >> 32;
        end
        return $signed(c03) - $signed((c3297 * e) >> 32);
    endfunction

endpackage

// ===== rtl/iace_dly.sv =====
// Enabled delay line for payload that rides alongside the multiplier stages.
// No dependencies.
module iace_dly #(
    parameter int unsigned W = 64,
    parameter int unsigned D = 3
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_q [D];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= i_d;
            for (int k = 1; k < D; k++) begin
                r_q[k] <= r_q[k-1];
            end
        end
    end

    assign o_q = r_q[D-1];

endmodule

// ===== rtl/iace_mul.sv =====
// Three-stage signed 64x64 multiply, floor shift right and 64-bit saturation.
// Uses iace_pkg.
module iace_mul #(
    parameter int unsigned SHIFT = 32
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  iace_pkg::t_q32 i_a,
    input  iace_pkg::t_q32 i_b,
    output iace_pkg::t_q32 o_p
);

    logic [63:0]  r_ua;
    logic [63:0]  r_ub;
    logic         r_neg1;
    logic [63:0]  r_p00;
    logic [63:0]  r_p01;
    logic [63:0]  r_p10;
    logic [63:0]  r_p11;
    logic         r_neg2;
    iace_pkg::t_q32 r_p;

    logic [127:0]         w_mag;
    logic signed [127:0]  w_val;
    logic signed [127:0]  w_q;
    iace_pkg::t_q32       n_p;

    // Stage 1: magnitudes and sign; stage 2: 32x32 partial products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ua   <= i_a[63] ? (~i_a + 64'd1) : i_a;
            r_ub   <= i_b[63] ? (~i_b + 64'd1) : i_b;
            r_neg1 <= i_a[63] ^ i_b[63];
            r_p00  <= r_ua[31:0]  * r_ub[31:0];
            r_p01  <= r_ua[31:0]  * r_ub[63:32];
            r_p10  <= r_ua[63:32] * r_ub[31:0];
            r_p11  <= r_ua[63:32] * r_ub[63:32];
            r_neg2 <= r_neg1;
            r_p    <= n_p;
        end
    end

    always_comb begin
        w_mag = {r_p11, 64'd0} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0}
              + {64'd0, r_p00};
        w_val = r_neg2 ? -$signed(w_mag) : $signed(w_mag);
        w_q   = w_val >>> SHIFT;
        if (w_q > 128'sh7FFF_FFFF_FFFF_FFFF) begin
            n_p = {1'b0, {63{1'b1}}};
        end else if (w_q < -128'sh8000_0000_0000_0000) begin
            n_p = {1'b1, 63'd0};
        end else begin
            n_p = w_q[63:0];
        end
    end

    assign o_p = r_p;

endmodule

// ===== rtl/iace_poly.sv =====
// Horner evaluation of a curve fit with one pipelined multiplier per Horner step.
// Uses iace_pkg, iace_mul and iace_dly.
module iace_poly #(
    parameter int unsigned N = 5
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  iace_pkg::t_coef5 i_coef,
    input  iace_pkg::t_q32  i_x,
    output iace_pkg::t_q32  o_y
);

    iace_pkg::t_q32 w_acc [N];
    iace_pkg::t_q32 w_x   [N-1];
    iace_pkg::t_q32 w_prd [1:N-1];

    assign w_acc[0] = i_coef[0];
    assign w_x[0]   = i_x;

    for (genvar k = 1; k < N; k++) begin : g_term
        iace_mul #(.SHIFT(32)) u_mul (
            .i_clk(i_clk), .i_en(i_en), .i_a(w_acc[k-1]), .i_b(w_x[k-1]), .o_p(w_prd[k])
        );
        // The last step needs no delayed copy of x
        if (k < N - 1) begin : g_dly_x
            iace_dly #(.W(64), .D(iace_pkg::MUL_LAT)) u_dly_x (
                .i_clk(i_clk), .i_en(i_en), .i_d(w_x[k-1]), .o_q(w_x[k])
            );
        end
        assign w_acc[k] = iace_pkg::sat_add(w_prd[k], i_coef[k]);
    end

    assign o_y = w_acc[N-1];

endmodule

// ===== rtl/iace_sev.sv =====
// Wing icing severity map: linear below the knee, interpolated exponential
// table above it. Uses iace_pkg, iace_mul and iace_dly.
module iace_sev #(
    parameter int unsigned DEPTH = 64
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [16:0]    i_sum,
    output iace_pkg::t_q32 o_e
);

    localparam int unsigned TW = $clog2(DEPTH + 1);
    localparam int unsigned PW = 17 + TW;

    iace_pkg::t_q32 w_tbl [DEPTH+1];

    for (genvar g = 0; g <= DEPTH; g++) begin : g_tbl
        assign w_tbl[g] = iace_pkg::sev_entry(DEPTH, g);
    end

    logic [PW-1:0]  w_p;
    logic [TW-1:0]  w_idx;
    logic           w_knee;
    logic [TW-1:0]  r_idx;
    logic [16:0]    r_fr;
    logic           r_knee;
    logic [16:0]    r_sum;
    iace_pkg::t_q32 r_lo;
    iace_pkg::t_q32 r_hi;
    logic [16:0]    r_fr2;
    logic           r_knee2;
    logic [16:0]    r_sum2;
    iace_pkg::t_q32 w_prd;
    logic [81:0]    w_side5;
    iace_pkg::t_q32 w_lo5;
    iace_pkg::t_q32 n_e;
    iace_pkg::t_q32 r_e;

    always_comb begin
        w_p    = PW'(i_sum) * PW'(DEPTH);
        w_idx  = w_p[PW-1:17];
        w_knee = (21'(i_sum) * 21'd10) <= 21'd65536;
        if (w_p[PW-1:17] >= TW'(DEPTH)) begin
            w_idx = TW'(DEPTH - 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx   <= w_idx;
            r_fr    <= w_p[16:0];
            r_knee  <= w_knee;
            r_sum   <= i_sum;
            r_lo    <= w_tbl[r_idx];
            r_hi    <= w_tbl[r_idx + TW'(1)];
            r_fr2   <= r_fr;
            r_knee2 <= r_knee;
            r_sum2  <= r_sum;
            r_e     <= n_e;
        end
    end

    iace_mul #(.SHIFT(17)) u_mul_fr (
        .i_clk(i_clk), .i_en(i_en), .i_a(r_hi - r_lo), .i_b({47'd0, r_fr2}), .o_p(w_prd)
    );

    iace_dly #(.W(82), .D(iace_pkg::MUL_LAT)) u_dly_side (
        .i_clk(i_clk), .i_en(i_en), .i_d({r_lo, r_knee2, r_sum2}), .o_q(w_side5)
    );

    assign w_lo5 = w_side5[81:18];

    always_comb begin
        if (w_side5[17]) begin
            n_e = {31'd0, w_side5[16:0], 16'd0};
        end else begin
            n_e = iace_pkg::sat_add(w_lo5, w_prd);
        end
    end

    assign o_e = r_e;

endmodule

// ===== rtl/iced_aero_coefficient_increments_unit.sv =====
// Iced-aircraft aerodynamic coefficient increments, top level.
// Uses iace_pkg, iace_mul, iace_dly, iace_poly and iace_sev.
//
// Takes one operating point per clock and returns lift, drag, pitch, hinge, roll
// and yaw increments; the path is seven multiplier steps of three stages each
// (angle conversion, four Horner steps, scaling by the fit gain and by the icing
// severity) plus the output register. The whole pipeline advances together: it
// holds only while the output register carries a result that has not been taken,
// so with a ready sink the sustained rate is one item per cycle. The severity
// table has EXP_TABLE_DEPTH+1 entries, built at elaboration.
module iced_aero_coefficient_increments_unit #(
    parameter int unsigned EXP_TABLE_DEPTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // attack_angle, elevator_angle, ice_left_wing, ice_right_wing, ice_tail
    input  logic [79:0]  i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // lift, drag, pitch, hinge, roll, yaw increments
    output logic [191:0] o_m_tdata
);

    localparam int unsigned L = iace_pkg::MUL_LAT;

    logic w_en;
    logic [iace_pkg::PIPE_DEPTH-1:0] r_vld;
    logic         r_out_valid;
    logic [191:0] r_out_data;

    iace_pkg::t_q32 w_att, w_elv, w_a, w_d, w_a12, w_md, w_md12, w_ma, w_ma15;
    iace_pkg::t_q32 w_pl_lo, w_pl_hi, w_cha, w_pd, w_pma, w_pme;
    iace_pkg::t_q32 w_pl, w_hng, w_kcl, w_kch, w_e6, w_e15, w_pmd;
    iace_pkg::t_q32 w_kcd, w_kcma, w_kcmd, w_dcl, w_dcr, w_dch;
    iace_pkg::t_q32 w_dcd, w_dcy, w_m1, w_m2, w_dcm;
    iace_pkg::t_q32 w_et15, w_diff15, w_ew18, w_et18, w_diff18, w_wt18;
    logic [16:0] w_sum;
    logic [16:0] w_dif;
    logic [49:0] w_side15, w_side18;
    logic [191:0] w_late21;

    assign w_en       = !r_out_valid || i_m_tready;
    assign o_s_tready = w_en && i_rst_n;

    assign w_att = {{48{i_s_tdata[15]}}, i_s_tdata[15:0]};
    assign w_elv = {{48{i_s_tdata[31]}}, i_s_tdata[31:16]};
    assign w_sum = {1'b0, i_s_tdata[47:32]} + {1'b0, i_s_tdata[63:48]};
    assign w_dif = {1'b0, i_s_tdata[47:32]} - {1'b0, i_s_tdata[63:48]};

    // Angles to degrees
    iace_mul #(.SHIFT(14)) u_mul_a (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_att), .i_b(iace_pkg::DEG_PER_RAD), .o_p(w_a));
    iace_mul #(.SHIFT(14)) u_mul_d (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_elv), .i_b(iace_pkg::DEG_PER_RAD), .o_p(w_d));

    // Curve fits
    iace_poly #(.N(4)) u_poly_llo (
        .i_clk(i_clk), .i_en(w_en), .i_coef(iace_pkg::LIFT_LO_C), .i_x(w_a), .o_y(w_pl_lo));
    iace_poly #(.N(4)) u_poly_lhi (
        .i_clk(i_clk), .i_en(w_en), .i_coef(iace_pkg::LIFT_HI_C), .i_x(w_a), .o_y(w_pl_hi));
    iace_poly #(.N(4)) u_poly_hng (
        .i_clk(i_clk), .i_en(w_en), .i_coef(iace_pkg::HINGE_A_C), .i_x(w_a), .o_y(w_cha));
    iace_poly #(.N(5)) u_poly_drg (
        .i_clk(i_clk), .i_en(w_en), .i_coef(iace_pkg::DRAG_C), .i_x(w_a), .o_y(w_pd));
    iace_poly #(.N(5)) u_poly_pma (
        .i_clk(i_clk), .i_en(w_en), .i_coef(iace_pkg::PITCH_A_C), .i_x(w_a), .o_y(w_pma));
    iace_poly #(.N(5)) u_poly_pme (
        .i_clk(i_clk), .i_en(w_en), .i_coef(iace_pkg::PITCH_E_C), .i_x(w_d), .o_y(w_pme));

    iace_mul #(.SHIFT(32)) u_mul_ma (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_a), .i_b(iace_pkg::PM_EA), .o_p(w_ma));
    iace_mul #(.SHIFT(32)) u_mul_md (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_d), .i_b(iace_pkg::HM_ED), .o_p(w_md));

    iace_dly #(.W(64), .D(3 * L)) u_dly_a (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_a), .o_q(w_a12));
    iace_dly #(.W(64), .D(2 * L)) u_dly_md (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_md), .o_q(w_md12));
    iace_dly #(.W(64), .D(3 * L)) u_dly_ma (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_ma), .o_q(w_ma15));

    // Lift and hinge splits on the degree value
    assign w_pl  = (w_a12 < iace_pkg::LIFT_SPLIT) ? w_pl_lo : w_pl_hi;
    assign w_hng = iace_pkg::sat_add((w_a12 < iace_pkg::HINGE_SPLIT) ? w_cha : '0,
                                     iace_pkg::sat_add(iace_pkg::HM_E0, w_md12));

    iace_mul #(.SHIFT(1)) u_mul_kcl (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_pl), .i_b(-64'sd25), .o_p(w_kcl));
    iace_mul #(.SHIFT(1)) u_mul_kch (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_hng), .i_b(64'sd10), .o_p(w_kch));

    iace_sev #(.DEPTH(EXP_TABLE_DEPTH)) u_sev (
        .i_clk(i_clk), .i_en(w_en), .i_sum(w_sum), .o_e(w_e6));
    iace_dly #(.W(64), .D(5 * L - 6)) u_dly_e (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_e6), .o_q(w_e15));

    // Severities travel narrow and are widened where used
    iace_dly #(.W(50), .D(5 * L)) u_dly_s15 (
        .i_clk(i_clk), .i_en(w_en), .i_d({w_sum, i_s_tdata[79:64], w_dif}), .o_q(w_side15));
    iace_dly #(.W(50), .D(L)) u_dly_s18 (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_side15), .o_q(w_side18));

    assign w_et15   = {31'd0, w_side15[32:17], 17'd0};
    assign w_diff15 = {{30{w_side15[16]}}, w_side15[16:0], 17'd0};
    assign w_ew18   = {31'd0, w_side18[49:33], 16'd0};
    assign w_et18   = {31'd0, w_side18[32:17], 17'd0};
    assign w_diff18 = {{30{w_side18[16]}}, w_side18[16:0], 17'd0};
    assign w_wt18   = (w_ew18 + (w_ew18 <<< 1) + w_et18) >>> 2;

    assign w_pmd = iace_pkg::sat_add(w_pme, iace_pkg::sat_add(iace_pkg::PM_E0, w_ma15));

    iace_mul #(.SHIFT(1)) u_mul_kcd (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_pd), .i_b(-64'sd25), .o_p(w_kcd));
    iace_mul #(.SHIFT(1)) u_mul_kcma (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_pma), .i_b(64'sd25), .o_p(w_kcma));
    iace_mul #(.SHIFT(1)) u_mul_kcmd (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_pmd), .i_b(64'sd10), .o_p(w_kcmd));
    iace_mul #(.SHIFT(32)) u_mul_dcl (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_e15), .i_b(w_kcl), .o_p(w_dcl));
    iace_mul #(.SHIFT(35)) u_mul_dcr (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_diff15), .i_b(w_kcl), .o_p(w_dcr));
    iace_mul #(.SHIFT(32)) u_mul_dch (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_et15), .i_b(w_kch), .o_p(w_dch));

    iace_mul #(.SHIFT(32)) u_mul_dcd (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_ew18), .i_b(w_kcd), .o_p(w_dcd));
    iace_mul #(.SHIFT(35)) u_mul_dcy (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_diff18), .i_b(w_kcd), .o_p(w_dcy));
    iace_mul #(.SHIFT(32)) u_mul_m1 (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_wt18), .i_b(w_kcma), .o_p(w_m1));
    iace_mul #(.SHIFT(32)) u_mul_m2 (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_et18), .i_b(w_kcmd), .o_p(w_m2));

    iace_dly #(.W(192), .D(L)) u_dly_late (
        .i_clk(i_clk), .i_en(w_en), .i_d({w_dch, w_dcr, w_dcl}), .o_q(w_late21));

    assign w_dcm = iace_pkg::sat_add(w_m1, w_m2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld       <= {r_vld[iace_pkg::PIPE_DEPTH-2:0], i_s_tvalid};
            r_out_valid <= r_vld[iace_pkg::PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= {iace_pkg::to_out(w_dcy),
                           iace_pkg::to_out(w_late21[127:64]),
                           iace_pkg::to_out(w_late21[191:128]),
                           iace_pkg::to_out(w_dcm),
                           iace_pkg::to_out(w_dcd),
                           iace_pkg::to_out(w_late21[63:0])};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[iace_pkg::PIPE_DEPTH-1] && o_s_tready |=> o_m_tvalid)
        else $error("result in last stage did not reach the output register");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_vld[0])
        else $error("accepted transfer did not enter the pipeline");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |=> $stable(r_vld))
        else $error("pipeline moved during a stall");

endmodule
